@@ hdl/cop_pkg.sv @@
// Shared types, codes and sizes for the cross-owner box pair finder.
// No dependencies; the top level and the testbench use it by scoped names.
package cop_pkg;

   localparam int BOX_DEPTH    = 16;
   localparam int ISLAND_DEPTH = 16;
   localparam int WORKER_DEPTH = 8;
   localparam int PAIR_MAX     = 64;
   localparam int AXES         = 3;

   localparam int BOX_AW  = $clog2(BOX_DEPTH);
   localparam int CNT_W   = $clog2(BOX_DEPTH + 1);
   localparam int PAIR_W  = $clog2(PAIR_MAX + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_PROXY_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_LIMIT  = 1'd1;

   localparam logic [2:0] CMD_PUBLISH    = 3'd0;
   localparam logic [2:0] CMD_QUERY      = 3'd1;
   localparam logic [2:0] CMD_SET_ISLAND = 3'd2;
   localparam logic [2:0] CMD_ONLINE     = 3'd3;
   localparam logic [2:0] CMD_OFFLINE    = 3'd4;
   localparam logic [2:0] CMD_ERASE      = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [63:0]        island_id;
      logic [15:0]        worker_id;
      logic [31:0]        epoch;
      logic [63:0]        start;
      logic [31:0]        horizon;
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
   } box_row_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_PUB_L1, S_PUB_L2, S_SRCH_RD, S_SRCH_CMP, S_INS_CHK,
      S_SHIFT_RD, S_SHIFT_WR, S_ER_RD, S_ER_CMP, S_ER_MV_RD, S_ER_MV_WR,
      S_Q_RD, S_Q_L1, S_Q_L2, S_QA, S_QA_HOLD, S_QB, S_QB_CMP, S_Q_END, S_RESP
   } state_type;

   function automatic logic boxes_touch(box_row_type a, box_row_type b);
      boxes_touch = !(a.max_x < b.min_x || b.max_x < a.min_x ||
                      a.max_y < b.min_y || b.max_y < a.min_y ||
                      a.max_z < b.min_z || b.max_z < a.min_z);
   endfunction

endpackage

@@ hdl/cop_req_if.sv @@
// Request channel: valid/ready handshake with one command item.
// Depends on nothing.
interface cop_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic [63:0]        island_id;
   logic [15:0]        worker_id;
   logic [31:0]        epoch;
   logic [63:0]        tick_value;
   logic [31:0]        horizon;
   logic signed [31:0] min_x;
   logic signed [31:0] min_y;
   logic signed [31:0] min_z;
   logic signed [31:0] max_x;
   logic signed [31:0] max_y;
   logic signed [31:0] max_z;

   modport source(output valid, cmd, island_id, worker_id, epoch, tick_value, horizon,
                  min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink(input valid, cmd, island_id, worker_id, epoch, tick_value, horizon,
                min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

@@ hdl/cop_rsp_if.sv @@
// Response channel: valid/ready handshake with one result item.
// Depends on nothing.
interface cop_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        pair_valid;
   logic [63:0] first_island;
   logic [63:0] second_island;
   logic        last;

   modport source(output valid, status, pair_valid, first_island, second_island, last,
                  input ready);
   modport sink(input valid, status, pair_valid, first_island, second_island, last,
                output ready);
endinterface

@@ hdl/cross_owner_aabb_pair_finder.sv @@
// Cross-owner box pair finder top level: sequencer around the box table memory.
// Depends on cop_pkg, cop_req_if and cop_rsp_if.
//
// One item is processed at a time; req ready is high only while the sequencer
// is idle, and a finished result waits in the output register while the next
// item is taken. Ownership commands are decided in the decode state. A publish
// does an owner lookup, a search that reads one entry at a time, then a
// read/write move of each later entry through the table memory; an erase
// searches the same way and moves each later entry down. A query reads each box
// to qualify it against the owner tables, then reads each qualified first box
// and each candidate pair from the memory; output stalls can hold it.
module cross_owner_aabb_pair_finder (
   input  logic                            clock,
   input  logic                            reset,
   cop_req_if.sink                         req_ch,
   cop_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [cop_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cop_pkg::CSR_W-1:0]       csr_data
);

   localparam int AW  = cop_pkg::BOX_AW;
   localparam int CW  = cop_pkg::CNT_W;
   localparam int PW  = cop_pkg::PAIR_W;
   localparam int NI  = cop_pkg::ISLAND_DEPTH;
   localparam int NW  = cop_pkg::WORKER_DEPTH;
   localparam int IAW = $clog2(NI);
   localparam int WAW = $clog2(NW);

   cop_pkg::state_type   state_ff, state_in;
   logic [4:0]           proxy_limit_ff;
   logic [6:0]           pair_limit_ff;

   logic [2:0]           cmd_ff;
   cop_pkg::box_row_type it_ff;

   cop_pkg::box_row_type box_mem [cop_pkg::BOX_DEPTH];
   cop_pkg::box_row_type rd_ff;
   logic                 mem_re, mem_we;
   logic [AW-1:0]        mem_raddr, mem_waddr;
   cop_pkg::box_row_type mem_wdata;

   logic [CW-1:0]        count_ff, count_in, pos_ff, pos_in, idx_ff, idx_in, a_ff, a_in;
   cop_pkg::box_row_type a_row_ff, a_row_in;
   logic [cop_pkg::BOX_DEPTH-1:0] act_ff, act_in;
   logic [PW-1:0]        n_ff, n_in;
   logic                 pend_ff, pend_in;
   logic [63:0]          pend_f_ff, pend_f_in, pend_s_ff, pend_s_in;
   logic [1:0]           st_ff, st_in;

   logic                 own_used_ff [NI];
   logic [63:0]          own_id_ff   [NI];
   logic [15:0]          own_w_ff    [NI];
   logic [31:0]          own_ep_ff   [NI];
   logic [63:0]          own_st_ff   [NI];
   logic                 own_we;
   logic [IAW-1:0]       own_widx;

   logic                 wk_used_ff [NW];
   logic                 wk_on_ff   [NW];
   logic [15:0]          wk_id_ff   [NW];
   logic                 wk_we, wk_new, wk_on_val;
   logic [WAW-1:0]       wk_widx;

   logic                 l1_hit_ff, win_ff;
   logic [15:0]          l1_w_ff;
   logic [31:0]          l1_ep_ff;
   logic [63:0]          l1_st_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_pv_ff, rsp_last_ff;
   logic [63:0]          rsp_f_ff, rsp_s_ff;
   logic                 emit, e_pv, e_last;
   logic [1:0]           e_status;
   logic [63:0]          e_f, e_s;
   logic                 out_free;

   // lookup unit
   cop_pkg::box_row_type lk_row;
   logic                 isl_hit, isl_free_found, wk_hit, wk_free_found, auth_ok, win_ok;
   logic [IAW-1:0]       isl_idx, isl_free;
   logic [WAW-1:0]       wk_idx, wk_free;
   logic [15:0]          s1_w;
   logic [31:0]          s1_ep;
   logic [63:0]          s1_st;
   logic                 wk_ok;
   logic [64:0]          end_sum;
   logic [63:0]          win_end;
   logic [CW-1:0]        box_lim;
   logic [PW-1:0]        pair_lim;
   logic                 bounds_bad;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == cop_pkg::S_IDLE);
   assign lk_row = (cmd_ff == cop_pkg::CMD_QUERY) ? rd_ff : it_ff;

   always_comb begin
      if (proxy_limit_ff == 5'd0) box_lim = CW'(1);
      else if (int'(proxy_limit_ff) > cop_pkg::BOX_DEPTH) box_lim = CW'(cop_pkg::BOX_DEPTH);
      else box_lim = CW'(proxy_limit_ff);
      if (pair_limit_ff == 7'd0) pair_lim = PW'(1);
      else if (int'(pair_limit_ff) > cop_pkg::PAIR_MAX) pair_lim = PW'(cop_pkg::PAIR_MAX);
      else pair_lim = PW'(pair_limit_ff);
   end

   // island and worker match lines
   always_comb begin
      isl_hit = 1'b0;
      isl_idx = '0;
      isl_free_found = 1'b0;
      isl_free = '0;
      for (int i = 0; i < NI; i++) begin
         if (own_used_ff[i] && own_id_ff[i] == lk_row.island_id) begin
            isl_hit = 1'b1;
            isl_idx = IAW'(i);
         end
         if (!own_used_ff[i] && !isl_free_found) begin
            isl_free_found = 1'b1;
            isl_free = IAW'(i);
         end
      end
      s1_w  = own_w_ff[isl_idx];
      s1_ep = own_ep_ff[isl_idx];
      s1_st = own_st_ff[isl_idx];
      wk_hit = 1'b0;
      wk_idx = '0;
      wk_free_found = 1'b0;
      wk_free = '0;
      wk_ok = 1'b0;
      for (int k = 0; k < NW; k++) begin
         if (wk_used_ff[k] && wk_id_ff[k] == it_ff.worker_id) begin
            wk_hit = 1'b1;
            wk_idx = WAW'(k);
         end
         if (!wk_used_ff[k] && !wk_free_found) begin
            wk_free_found = 1'b1;
            wk_free = WAW'(k);
         end
         if (wk_used_ff[k] && wk_on_ff[k] && wk_id_ff[k] == l1_w_ff) wk_ok = 1'b1;
      end
      auth_ok = l1_hit_ff && wk_ok && l1_w_ff == lk_row.worker_id &&
                l1_ep_ff == lk_row.epoch && lk_row.start >= l1_st_ff;
      end_sum = {1'b0, lk_row.start} + {33'd0, lk_row.horizon};
      win_end = end_sum[64] ? '1 : end_sum[63:0];
      win_ok  = it_ff.start >= lk_row.start && it_ff.start <= win_end;
      bounds_bad = it_ff.max_x < it_ff.min_x || it_ff.max_y < it_ff.min_y ||
                   it_ff.max_z < it_ff.min_z;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      a_in     = a_ff;
      a_row_in = a_row_ff;
      act_in   = act_ff;
      n_in     = n_ff;
      pend_in  = pend_ff;
      pend_f_in = pend_f_ff;
      pend_s_in = pend_s_ff;
      st_in    = st_ff;
      mem_re = 1'b0;
      mem_raddr = pos_ff[AW-1:0];
      mem_we = 1'b0;
      mem_waddr = pos_ff[AW-1:0];
      mem_wdata = it_ff;
      own_we = 1'b0;
      own_widx = isl_idx;
      wk_we = 1'b0;
      wk_new = 1'b0;
      wk_on_val = 1'b0;
      wk_widx = wk_idx;
      emit = 1'b0;
      e_status = cop_pkg::ST_OK;
      e_pv = 1'b0;
      e_f = '0;
      e_s = '0;
      e_last = 1'b1;
      unique case (state_ff)
         cop_pkg::S_IDLE: begin
            if (req_ch.valid) state_in = cop_pkg::S_DECODE;
         end
         cop_pkg::S_DECODE: begin
            state_in = cop_pkg::S_RESP;
            st_in = cop_pkg::ST_OK;
            pos_in = '0;
            idx_in = '0;
            act_in = '0;
            n_in = '0;
            pend_in = 1'b0;
            unique case (cmd_ff)
               cop_pkg::CMD_PUBLISH: state_in = cop_pkg::S_PUB_L1;
               cop_pkg::CMD_QUERY:   state_in = cop_pkg::S_Q_RD;
               cop_pkg::CMD_ERASE:   state_in = cop_pkg::S_ER_RD;
               cop_pkg::CMD_SET_ISLAND: begin
                  if (isl_hit) begin
                     own_we = 1'b1;
                  end else if (isl_free_found) begin
                     own_we = 1'b1;
                     own_widx = isl_free;
                  end else begin
                     st_in = cop_pkg::ST_FULL;
                  end
               end
               cop_pkg::CMD_ONLINE: begin
                  wk_on_val = 1'b1;
                  if (wk_hit) begin
                     wk_we = 1'b1;
                  end else if (wk_free_found) begin
                     wk_we = 1'b1;
                     wk_new = 1'b1;
                     wk_widx = wk_free;
                  end else begin
                     st_in = cop_pkg::ST_FULL;
                  end
               end
               cop_pkg::CMD_OFFLINE: begin
                  if (wk_hit) wk_we = 1'b1;
                  else st_in = cop_pkg::ST_REJECT;
               end
               default: st_in = cop_pkg::ST_REJECT;
            endcase
         end
         cop_pkg::S_PUB_L1: state_in = cop_pkg::S_PUB_L2;
         cop_pkg::S_PUB_L2: begin
            if (!auth_ok || it_ff.horizon == 32'd0 || bounds_bad) begin
               st_in = cop_pkg::ST_REJECT;
               state_in = cop_pkg::S_RESP;
            end else begin
               state_in = cop_pkg::S_SRCH_RD;
            end
         end
         cop_pkg::S_SRCH_RD: begin
            if (pos_ff < count_ff) begin
               mem_re = 1'b1;
               state_in = cop_pkg::S_SRCH_CMP;
            end else begin
               state_in = cop_pkg::S_INS_CHK;
            end
         end
         cop_pkg::S_SRCH_CMP: begin
            if (rd_ff.island_id < it_ff.island_id) begin
               pos_in = pos_ff + CW'(1);
               state_in = cop_pkg::S_SRCH_RD;
            end else if (rd_ff.island_id == it_ff.island_id) begin
               state_in = cop_pkg::S_RESP;
               if (it_ff.start < rd_ff.start) begin
                  st_in = cop_pkg::ST_REJECT;
               end else begin
                  mem_we = 1'b1;
                  st_in = cop_pkg::ST_OK;
               end
            end else begin
               state_in = cop_pkg::S_INS_CHK;
            end
         end
         cop_pkg::S_INS_CHK: begin
            if (count_ff >= box_lim) begin
               st_in = cop_pkg::ST_FULL;
               state_in = cop_pkg::S_RESP;
            end else begin
               idx_in = count_ff;
               state_in = cop_pkg::S_SHIFT_RD;
            end
         end
         cop_pkg::S_SHIFT_RD: begin
            // open a slot at pos by moving later entries up one
            if (idx_ff > pos_ff) begin
               mem_re = 1'b1;
               mem_raddr = AW'(idx_ff - CW'(1));
               state_in = cop_pkg::S_SHIFT_WR;
            end else begin
               mem_we = 1'b1;
               count_in = count_ff + CW'(1);
               st_in = cop_pkg::ST_OK;
               state_in = cop_pkg::S_RESP;
            end
         end
         cop_pkg::S_SHIFT_WR: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_ff;
            idx_in = idx_ff - CW'(1);
            state_in = cop_pkg::S_SHIFT_RD;
         end
         cop_pkg::S_ER_RD: begin
            if (pos_ff < count_ff) begin
               mem_re = 1'b1;
               state_in = cop_pkg::S_ER_CMP;
            end else begin
               st_in = cop_pkg::ST_REJECT;
               state_in = cop_pkg::S_RESP;
            end
         end
         cop_pkg::S_ER_CMP: begin
            if (rd_ff.island_id == it_ff.island_id) begin
               idx_in = pos_ff;
               state_in = cop_pkg::S_ER_MV_RD;
            end else begin
               pos_in = pos_ff + CW'(1);
               state_in = cop_pkg::S_ER_RD;
            end
         end
         cop_pkg::S_ER_MV_RD: begin
            if (idx_ff + CW'(1) < count_ff) begin
               mem_re = 1'b1;
               mem_raddr = AW'(idx_ff + CW'(1));
               state_in = cop_pkg::S_ER_MV_WR;
            end else begin
               count_in = count_ff - CW'(1);
               st_in = cop_pkg::ST_OK;
               state_in = cop_pkg::S_RESP;
            end
         end
         cop_pkg::S_ER_MV_WR: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_ff;
            idx_in = idx_ff + CW'(1);
            state_in = cop_pkg::S_ER_MV_RD;
         end
         cop_pkg::S_Q_RD: begin
            if (idx_ff < count_ff) begin
               mem_re = 1'b1;
               mem_raddr = idx_ff[AW-1:0];
               state_in = cop_pkg::S_Q_L1;
            end else begin
               a_in = '0;
               state_in = cop_pkg::S_QA;
            end
         end
         cop_pkg::S_Q_L1: state_in = cop_pkg::S_Q_L2;
         cop_pkg::S_Q_L2: begin
            act_in[idx_ff[AW-1:0]] = auth_ok && win_ff;
            idx_in = idx_ff + CW'(1);
            state_in = cop_pkg::S_Q_RD;
         end
         cop_pkg::S_QA: begin
            if (a_ff < count_ff && n_ff < pair_lim) begin
               if (act_ff[a_ff[AW-1:0]]) begin
                  mem_re = 1'b1;
                  mem_raddr = a_ff[AW-1:0];
                  state_in = cop_pkg::S_QA_HOLD;
               end else begin
                  a_in = a_ff + CW'(1);
               end
            end else begin
               state_in = cop_pkg::S_Q_END;
            end
         end
         cop_pkg::S_QA_HOLD: begin
            a_row_in = rd_ff;
            idx_in = a_ff + CW'(1);
            state_in = cop_pkg::S_QB;
         end
         cop_pkg::S_QB: begin
            if (idx_ff < count_ff && n_ff < pair_lim) begin
               if (act_ff[idx_ff[AW-1:0]]) begin
                  mem_re = 1'b1;
                  mem_raddr = idx_ff[AW-1:0];
                  state_in = cop_pkg::S_QB_CMP;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               a_in = a_ff + CW'(1);
               state_in = cop_pkg::S_QA;
            end
         end
         cop_pkg::S_QB_CMP: begin
            if (a_row_ff.worker_id != rd_ff.worker_id && cop_pkg::boxes_touch(a_row_ff, rd_ff))
            begin
               // one pair is held back so the final one can carry last
               if (!pend_ff || out_free) begin
                  emit = pend_ff;
                  e_pv = 1'b1;
                  e_f = pend_f_ff;
                  e_s = pend_s_ff;
                  e_last = 1'b0;
                  pend_in = 1'b1;
                  pend_f_in = a_row_ff.island_id;
                  pend_s_in = rd_ff.island_id;
                  n_in = n_ff + PW'(1);
                  idx_in = idx_ff + CW'(1);
                  state_in = cop_pkg::S_QB;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = cop_pkg::S_QB;
            end
         end
         cop_pkg::S_Q_END: begin
            if (out_free) begin
               emit = 1'b1;
               e_pv = pend_ff;
               e_f = pend_ff ? pend_f_ff : 64'd0;
               e_s = pend_ff ? pend_s_ff : 64'd0;
               pend_in = 1'b0;
               state_in = cop_pkg::S_IDLE;
            end
         end
         cop_pkg::S_RESP: begin
            if (out_free) begin
               emit = 1'b1;
               e_status = st_ff;
               state_in = cop_pkg::S_IDLE;
            end
         end
         default: state_in = cop_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cop_pkg::S_IDLE;
         proxy_limit_ff <= 5'd16;
         pair_limit_ff <= 7'd64;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NI; i++) own_used_ff[i] <= 1'b0;
         for (int k = 0; k < NW; k++) begin
            wk_used_ff[k] <= 1'b0;
            wk_on_ff[k] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         if (csr_we) begin
            unique case (csr_index)
               cop_pkg::CSR_PROXY_LIMIT: proxy_limit_ff <= csr_data[4:0];
               cop_pkg::CSR_PAIR_LIMIT:  pair_limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (own_we) own_used_ff[own_widx] <= 1'b1;
         if (wk_we) begin
            wk_on_ff[wk_widx] <= wk_on_val;
            if (wk_new) wk_used_ff[wk_widx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         cmd_ff <= req_ch.cmd;
         it_ff.island_id <= req_ch.island_id;
         it_ff.worker_id <= req_ch.worker_id;
         it_ff.epoch <= req_ch.epoch;
         it_ff.start <= req_ch.tick_value;
         it_ff.horizon <= req_ch.horizon;
         it_ff.min_x <= req_ch.min_x;
         it_ff.min_y <= req_ch.min_y;
         it_ff.min_z <= req_ch.min_z;
         it_ff.max_x <= req_ch.max_x;
         it_ff.max_y <= req_ch.max_y;
         it_ff.max_z <= req_ch.max_z;
      end
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      a_ff <= a_in;
      a_row_ff <= a_row_in;
      act_ff <= act_in;
      n_ff <= n_in;
      pend_f_ff <= pend_f_in;
      pend_s_ff <= pend_s_in;
      st_ff <= st_in;
      l1_hit_ff <= isl_hit;
      l1_w_ff <= s1_w;
      l1_ep_ff <= s1_ep;
      l1_st_ff <= s1_st;
      win_ff <= win_ok;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_pv_ff <= e_pv;
         rsp_f_ff <= e_f;
         rsp_s_ff <= e_s;
         rsp_last_ff <= e_last;
      end
      if (own_we) begin
         own_id_ff[own_widx] <= it_ff.island_id;
         own_w_ff[own_widx] <= it_ff.worker_id;
         own_ep_ff[own_widx] <= it_ff.epoch;
         own_st_ff[own_widx] <= it_ff.start;
      end
      if (wk_we && wk_new) wk_id_ff[wk_widx] <= it_ff.worker_id;
   end

   // box table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) box_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= box_mem[mem_raddr];
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.pair_valid = rsp_pv_ff;
   assign rsp_ch.first_island = rsp_f_ff;
   assign rsp_ch.second_island = rsp_s_ff;
   assign rsp_ch.last = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= cop_pkg::BOX_DEPTH)
      else $error("box count beyond table depth");
   a_pair_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= pair_lim || state_ff == cop_pkg::S_IDLE || state_ff == cop_pkg::S_DECODE)
      else $error("pair count beyond limit");
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == cop_pkg::S_IDLE |-> !pend_ff)
      else $error("held pair left behind");
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrites a waiting item");
`endif

endmodule

@@ tb/testbench.sv @@
// Testbench for cross_owner_aabb_pair_finder: directed table, then random phases.
// Depends on cop_pkg, cop_req_if, cop_rsp_if and the block itself.
`timescale 1ns / 100ps

module testbench;

   localparam logic [63:0] TICK_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD   = 2000;
   localparam int ITEMS_PER_PHASE = 89;

   typedef struct {
      logic [2:0]  cmd;
      cop_pkg::box_row_type b;      // b.start carries tick_value
   } cmd_item_type;

   typedef struct {
      logic [1:0]  status;
      logic        pair_valid;
      logic [63:0] first_island;
      logic [63:0] second_island;
      logic        last;
   } result_type;

   typedef struct {
      cmd_item_type it;
      bit           typed;
      logic [1:0]   status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [cop_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cop_pkg::CSR_W-1:0] csr_data;

   cop_req_if req_ch();
   cop_rsp_if rsp_ch();

   cross_owner_aabb_pair_finder u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the block's tables
   cop_pkg::box_row_type boxes [cop_pkg::BOX_DEPTH];
   int          box_n;
   logic [63:0] own_id    [cop_pkg::ISLAND_DEPTH];
   logic [15:0] own_w     [cop_pkg::ISLAND_DEPTH];
   logic [31:0] own_ep    [cop_pkg::ISLAND_DEPTH];
   logic [63:0] own_start [cop_pkg::ISLAND_DEPTH];
   bit          own_used  [cop_pkg::ISLAND_DEPTH];
   logic [15:0] wk_id     [cop_pkg::WORKER_DEPTH];
   bit          wk_on     [cop_pkg::WORKER_DEPTH];
   bit          wk_used   [cop_pkg::WORKER_DEPTH];
   logic [4:0]  box_cap_reg;
   logic [6:0]  pair_cap_reg;

   result_type pair_results[$];     // produced by the predictor for one item
   result_type pending_results[$];  // awaiting the block

   int errors = 0;
   int items_sent = 0, results_seen = 0, pairs_seen = 0, full_seen = 0;
   int sender_idle = 0, receiver_stall = 0;
   int cycles = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int hold_done = 0;

   function automatic void note_fail(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
   endfunction

   function automatic int island_slot(logic [63:0] id);
      for (int i = 0; i < cop_pkg::ISLAND_DEPTH; i++)
         if (own_used[i] && own_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int worker_slot(logic [15:0] w);
      for (int i = 0; i < cop_pkg::WORKER_DEPTH; i++)
         if (wk_used[i] && wk_id[i] == w) return i;
      return -1;
   endfunction

   function automatic bit owner_grants(logic [63:0] id, logic [15:0] w, logic [31:0] ep,
                                       logic [63:0] start);
      int s, k;
      s = island_slot(id);
      if (s < 0) return 0;
      k = worker_slot(own_w[s]);
      if (k < 0 || !wk_on[k]) return 0;
      return own_w[s] == w && own_ep[s] == ep && start >= own_start[s];
   endfunction

   function automatic bit box_live(int i, logic [63:0] tick);
      logic [64:0] sum;
      logic [63:0] stop;
      sum  = {1'b0, boxes[i].start} + {33'd0, boxes[i].horizon};
      stop = sum[64] ? TICK_MAX : sum[63:0];
      if (!owner_grants(boxes[i].island_id, boxes[i].worker_id, boxes[i].epoch,
                        boxes[i].start)) return 0;
      return tick >= boxes[i].start && tick <= stop;
   endfunction

   function automatic bit overlap3(cop_pkg::box_row_type a, cop_pkg::box_row_type b);
      if (a.max_x < b.min_x || b.max_x < a.min_x) return 0;
      if (a.max_y < b.min_y || b.max_y < a.min_y) return 0;
      if (a.max_z < b.min_z || b.max_z < a.min_z) return 0;
      return 1;
   endfunction

   function automatic logic [1:0] publish_box(cop_pkg::box_row_type r);
      int pos, cap;
      if (r.horizon == 0 || !owner_grants(r.island_id, r.worker_id, r.epoch, r.start))
         return cop_pkg::ST_REJECT;
      if (r.max_x < r.min_x || r.max_y < r.min_y || r.max_z < r.min_z)
         return cop_pkg::ST_REJECT;
      pos = 0;
      while (pos < box_n && boxes[pos].island_id < r.island_id) pos++;
      if (pos < box_n && boxes[pos].island_id == r.island_id) begin
         if (r.start < boxes[pos].start) return cop_pkg::ST_REJECT;
         boxes[pos] = r;
         return cop_pkg::ST_OK;
      end
      cap = (box_cap_reg == 0) ? 1 : int'(box_cap_reg);
      if (cap > cop_pkg::BOX_DEPTH) cap = cop_pkg::BOX_DEPTH;
      if (box_n >= cap) return cop_pkg::ST_FULL;
      for (int i = box_n; i > pos; i--) boxes[i] = boxes[i-1];
      boxes[pos] = r;
      box_n++;
      return cop_pkg::ST_OK;
   endfunction

   function automatic void query_pairs(logic [63:0] tick);
      int cap, n;
      result_type r;
      cap = (pair_cap_reg == 0) ? 1 : int'(pair_cap_reg);
      if (cap > cop_pkg::PAIR_MAX) cap = cop_pkg::PAIR_MAX;
      n = 0;
      for (int a = 0; a < box_n && n < cap; a++) begin
         if (!box_live(a, tick)) continue;
         for (int b = a + 1; b < box_n && n < cap; b++) begin
            if (!box_live(b, tick) || boxes[a].worker_id == boxes[b].worker_id ||
                !overlap3(boxes[a], boxes[b])) continue;
            r = '{cop_pkg::ST_OK, 1'b1, boxes[a].island_id, boxes[b].island_id, 1'b0};
            pair_results = {pair_results, r};
            n++;
         end
      end
      if (n == 0) begin
         r = '{cop_pkg::ST_OK, 1'b0, 64'd0, 64'd0, 1'b1};
         pair_results = {pair_results, r};
      end else begin
         pair_results[n-1].last = 1'b1;
      end
   endfunction

   function automatic logic [1:0] set_owner(cop_pkg::box_row_type r);
      int s;
      s = island_slot(r.island_id);
      if (s < 0) begin
         for (int i = 0; i < cop_pkg::ISLAND_DEPTH && s < 0; i++) if (!own_used[i]) s = i;
         if (s < 0) return cop_pkg::ST_FULL;
      end
      own_used[s] = 1; own_id[s] = r.island_id; own_w[s] = r.worker_id;
      own_ep[s] = r.epoch; own_start[s] = r.start;
      return cop_pkg::ST_OK;
   endfunction

   function automatic logic [1:0] set_worker(logic [15:0] w, bit online);
      int s;
      s = worker_slot(w);
      if (s < 0) begin
         if (!online) return cop_pkg::ST_REJECT;
         for (int i = 0; i < cop_pkg::WORKER_DEPTH && s < 0; i++) if (!wk_used[i]) s = i;
         if (s < 0) return cop_pkg::ST_FULL;
         wk_used[s] = 1; wk_id[s] = w;
      end
      wk_on[s] = online;
      return cop_pkg::ST_OK;
   endfunction

   function automatic logic [1:0] erase_box(logic [63:0] id);
      int pos;
      pos = 0;
      while (pos < box_n && boxes[pos].island_id != id) pos++;
      if (pos >= box_n) return cop_pkg::ST_REJECT;
      for (int i = pos; i + 1 < box_n; i++) boxes[i] = boxes[i+1];
      box_n--;
      return cop_pkg::ST_OK;
   endfunction

   function automatic void predict_item(cmd_item_type it);
      logic [1:0] st;
      result_type r;
      pair_results.delete();
      case (it.cmd)
         cop_pkg::CMD_PUBLISH:    st = publish_box(it.b);
         cop_pkg::CMD_QUERY: begin
            query_pairs(it.b.start);
            return;
         end
         cop_pkg::CMD_SET_ISLAND: st = set_owner(it.b);
         cop_pkg::CMD_ONLINE:     st = set_worker(it.b.worker_id, 1);
         cop_pkg::CMD_OFFLINE:    st = set_worker(it.b.worker_id, 0);
         cop_pkg::CMD_ERASE:      st = erase_box(it.b.island_id);
         default:                 st = cop_pkg::ST_REJECT;
      endcase
      r = '{st, 1'b0, 64'd0, 64'd0, 1'b1};
      pair_results = {pair_results, r};
   endfunction

   function automatic cmd_item_type mk(logic [2:0] c, logic [63:0] id, logic [15:0] w,
                                       logic [31:0] ep, logic [63:0] t, logic [31:0] hz,
                                       logic signed [31:0] lo, logic signed [31:0] hi);
      cmd_item_type it;
      it.cmd = c;
      it.b = '{id, w, ep, t, hz, lo, lo, lo, hi, hi, hi};
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_worker();
      int r;
      r = $urandom_range(0, 11);
      if (r < 10) return 16'(r);
      if (r == 10) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [63:0] pick_island();
      int r;
      r = $urandom_range(0, 21);
      if (r == 0) return 64'd0;
      if (r == 1) return TICK_MAX;
      if (r == 2) return rand64();
      return 64'(r) * 64'd1000;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? C_MIN : C_MAX - 32'sd3000;
      return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
   endfunction

   function automatic logic [63:0] pick_start();
      if ($urandom_range(0, 9) == 0) return TICK_MAX - 64'($urandom_range(0, 600));
      return 64'($urandom_range(0, 500));
   endfunction

   // Mostly well-formed traffic drawn from the shadow tables, some noise.
   function automatic cmd_item_type gen_item();
      cmd_item_type it;
      int r, k;
      logic signed [31:0] lo;
      logic [415:0] raw;
      r = $urandom_range(0, 99);
      it = mk(cop_pkg::CMD_QUERY, pick_island(), pick_worker(), 32'($urandom_range(0, 3)),
              pick_start(), 32'($urandom_range(1, 500)), 0, 0);
      if (r < 8) begin
         it.cmd = cop_pkg::CMD_ONLINE;
         k = $urandom_range(0, cop_pkg::ISLAND_DEPTH - 1);
         if ($urandom_range(0, 1) && own_used[k]) it.b.worker_id = own_w[k];
      end else if (r < 11) begin
         it.cmd = cop_pkg::CMD_OFFLINE;
      end else if (r < 20) begin
         it.cmd = cop_pkg::CMD_SET_ISLAND;
         k = $urandom_range(0, cop_pkg::WORKER_DEPTH - 1);
         if ($urandom_range(0, 9) < 7 && wk_used[k]) it.b.worker_id = wk_id[k];
      end else if (r < 28) begin
         it.cmd = cop_pkg::CMD_ERASE;
         if (box_n > 0 && $urandom_range(0, 1))
            it.b.island_id = boxes[$urandom_range(0, box_n - 1)].island_id;
      end else if (r < 48) begin
         it.cmd = cop_pkg::CMD_QUERY;
         if (box_n > 0 && $urandom_range(0, 9) < 8)
            it.b.start = boxes[$urandom_range(0, box_n - 1)].start +
                         64'($urandom_range(0, 300));
         else if ($urandom_range(0, 1))
            it.b.start = rand64();
      end else if (r < 95) begin
         it.cmd = cop_pkg::CMD_PUBLISH;
         k = $urandom_range(0, cop_pkg::ISLAND_DEPTH - 1);
         if (own_used[k]) begin
            it.b.island_id = own_id[k];
            it.b.worker_id = own_w[k];
            it.b.epoch = own_ep[k];
            it.b.start = own_start[k] + 64'($urandom_range(0, 300));
            for (int i = 0; i < box_n; i++)
               if (boxes[i].island_id == own_id[k] && boxes[i].start > it.b.start)
                  it.b.start = boxes[i].start + 64'($urandom_range(0, 50));
         end
         lo = pick_coord(); it.b.min_x = lo; it.b.max_x = lo + 32'($urandom_range(0, 3000));
         lo = pick_coord(); it.b.min_y = lo; it.b.max_y = lo + 32'($urandom_range(0, 3000));
         lo = pick_coord(); it.b.min_z = lo; it.b.max_z = lo + 32'($urandom_range(0, 3000));
         if ($urandom_range(0, 19) == 0) it.b.horizon = $urandom_range(0, 1) ? 0 : '1;
         if ($urandom_range(0, 19) == 0) it.b.max_y = it.b.min_y - 1;
         if ($urandom_range(0, 19) == 0) it.b.epoch = it.b.epoch + 1;
      end else begin
         it.cmd = 3'($urandom_range(0, 7));
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         it.b = raw[399:0];
      end
      return it;
   endfunction

   task automatic send_item(cmd_item_type it, int idle_pct, bit typed = 0,
                            logic [1:0] typed_st = cop_pkg::ST_OK);
      result_type tr;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         sender_idle++;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= it.cmd;
      req_ch.island_id  <= it.b.island_id;
      req_ch.worker_id  <= it.b.worker_id;
      req_ch.epoch      <= it.b.epoch;
      req_ch.tick_value <= it.b.start;
      req_ch.horizon    <= it.b.horizon;
      req_ch.min_x      <= it.b.min_x;
      req_ch.min_y      <= it.b.min_y;
      req_ch.min_z      <= it.b.min_z;
      req_ch.max_x      <= it.b.max_x;
      req_ch.max_y      <= it.b.max_y;
      req_ch.max_z      <= it.b.max_z;
      do @(posedge clock); while (!req_ch.ready);
      predict_item(it);
      items_sent++;
      if (typed) begin
         tr = '{typed_st, 1'b0, 64'd0, 64'd0, 1'b1};
         pending_results = {pending_results, tr};
      end else begin
         pending_results = {pending_results, pair_results};
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limits(logic [6:0] boxes_lim, logic [6:0] pairs_lim);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= cop_pkg::CSR_PROXY_LIMIT; csr_data <= boxes_lim;
      @(posedge clock);
      box_cap_reg = boxes_lim[4:0];
      csr_index <= cop_pkg::CSR_PAIR_LIMIT; csr_data <= pairs_lim;
      @(posedge clock);
      pair_cap_reg = pairs_lim;
      csr_we <= 1'b0;
   endtask

   int stall_pct = 0;

   // long receiver hold, counted in cycles
   always @(posedge clock) begin
      if (hold_done != hold_asks) begin
         hold_done = hold_asks;
         hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   // result side: random stalls, long hold on request, checks in order
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.pair_valid) pairs_seen++;
         if (rsp_ch.status == cop_pkg::ST_FULL) full_seen++;
         if (pending_results.size() == 0) begin
            note_fail($sformatf("result with nothing expected: st=%0d pv=%0b %h %h last=%0b",
                      rsp_ch.status, rsp_ch.pair_valid, rsp_ch.first_island,
                      rsp_ch.second_island, rsp_ch.last));
         end else begin
            e = pending_results.pop_front();
            if (rsp_ch.status !== e.status || rsp_ch.pair_valid !== e.pair_valid ||
                rsp_ch.first_island !== e.first_island ||
                rsp_ch.second_island !== e.second_island || rsp_ch.last !== e.last)
               note_fail($sformatf("exp st=%0d pv=%0b %h %h last=%0b, got st=%0d pv=%0b %h %h last=%0b",
                         e.status, e.pair_valid, e.first_island, e.second_island, e.last,
                         rsp_ch.status, rsp_ch.pair_valid, rsp_ch.first_island,
                         rsp_ch.second_island, rsp_ch.last));
         end
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         receiver_stall++;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   dir_row_type directed[$];
   int send_idle [5] = '{0, 64, 0, 27, 27};
   int recv_stall[5] = '{0, 0, 64, 27, 27};
   logic [6:0] box_lims [5];
   logic [6:0] pair_lims[5];

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_data = '0;
      req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.island_id = '0; req_ch.worker_id = '0;
      req_ch.epoch = '0; req_ch.tick_value = '0; req_ch.horizon = '0;
      req_ch.min_x = '0; req_ch.min_y = '0; req_ch.min_z = '0;
      req_ch.max_x = '0; req_ch.max_y = '0; req_ch.max_z = '0;
      box_n = 0;
      box_cap_reg = 5'd16;
      pair_cap_reg = 7'd64;
      foreach (own_used[i]) begin own_used[i] = 0; own_id[i] = '0; end
      foreach (wk_used[i]) begin wk_used[i] = 0; wk_on[i] = 0; wk_id[i] = '0; end

      directed = '{
         '{mk(cop_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_OFFLINE, 0, 5, 0, 0, 0, 0, 0), 1, cop_pkg::ST_REJECT},
         '{mk(cop_pkg::CMD_ERASE, 10, 0, 0, 0, 0, 0, 0), 1, cop_pkg::ST_REJECT},
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 7, 100, 50, 0, 0), 1, cop_pkg::ST_REJECT},
         '{mk(3'd6, 0, 0, 0, 0, 0, 0, 0), 1, cop_pkg::ST_REJECT},
         '{mk(3'd7, TICK_MAX, 16'hFFFF, '1, TICK_MAX, '1, C_MAX, C_MIN), 1,
           cop_pkg::ST_REJECT},
         '{mk(cop_pkg::CMD_ONLINE, 0, 1, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_ONLINE, 0, 2, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_ONLINE, 0, 16'hFFFF, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_SET_ISLAND, 10, 1, 7, 100, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_SET_ISLAND, 20, 2, '1, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0), 1,
           cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_SET_ISLAND, 0, 16'hFFFF, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         // empty horizon
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 7, 100, 0, 0, 0), 1, cop_pkg::ST_REJECT},
         // inverted axes
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 7, 100, 50, 5, -5), 1, cop_pkg::ST_REJECT},
         // epoch mismatch
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 8, 100, 50, 0, 0), 1, cop_pkg::ST_REJECT},
         // before authority
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 7, 99, 50, 0, 0), 1, cop_pkg::ST_REJECT},
         '{mk(cop_pkg::CMD_PUBLISH, 10, 1, 7, 100, 50, C_MIN, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_PUBLISH, 20, 2, '1, 64'hFFFF_FFFF_FFFF_FFF0, '1, -10, C_MAX), 1,
           cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_PUBLISH, 20, 2, '1, 64'hFFFF_FFFF_FFFF_FFE0, 5, 0, 1), 1,
           cop_pkg::ST_REJECT},
         '{mk(cop_pkg::CMD_PUBLISH, 0, 16'hFFFF, 0, 120, '1, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_QUERY, 0, 0, 0, 120, 0, 0, 0), 0, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_QUERY, 0, 0, 0, TICK_MAX, 0, 0, 0), 0, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_OFFLINE, 0, 16'hFFFF, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_QUERY, 0, 0, 0, 130, 0, 0, 0), 0, cop_pkg::ST_OK},
         '{mk(cop_pkg::CMD_ERASE, 10, 0, 0, 0, 0, 0, 0), 1, cop_pkg::ST_OK}
      };
      box_lims  = '{7'd16, 7'd1, 7'd0, 7'd127, 7'($urandom_range(0, 127))};
      pair_lims = '{7'd64, 7'd1, 7'd0, 7'd127, 7'($urandom_range(0, 127))};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_item(directed[i].it, 0, directed[i].typed, directed[i].status);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_limits(box_lims[p], pair_lims[p]);
         stall_pct = recv_stall[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 0 && n == 30) hold_asks++;
            if (p == 1 && n == 40) wait_drained();
            send_item(gen_item(), send_idle[p]);
         end
         wait_drained();
      end

      stall_pct = 0;
      repeat (400) @(posedge clock);
      if (pending_results.size() != 0)
         note_fail($sformatf("%0d results never arrived", pending_results.size()));
      $display("Ran %0d items through five limit settings, %0d results, %0d pairs, %0d full",
               items_sent, results_seen, pairs_seen, full_seen);
      $display("Sender idled %0d cycles, receiver stalled %0d cycles, %0d mismatches",
               sender_idle, receiver_stall, errors);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/cop_pkg.sv
hdl/cop_req_if.sv
hdl/cop_rsp_if.sv
hdl/cross_owner_aabb_pair_finder.sv
tb/testbench.sv
